// ===== src/a85_pkg.sv =====
package a85_pkg;

    // Input item: one raw byte of the stream
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // Result item: one encoded character
    typedef struct packed {
        logic [6:0] char_code;
        logic       last_of_run;
        logic       stream_done;
    } t_result;

    // Group job from front to back
    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  n_dig;
        logic        zero_grp;
        logic        last;
    } t_job;

    // Converted group: characters, most significant first at index 0
    typedef struct packed {
        logic [4:0][6:0] chars;
        logic [2:0]      n_chr;
        logic            last;
    } t_chars;

    localparam int unsigned C_DIGITS     = 5;
    localparam logic [6:0]  C_CH_OFFSET  = 7'd33;
    localparam logic [6:0]  C_CH_Z       = 7'd122;
    localparam logic [6:0]  C_CH_NL      = 7'd10;
    localparam logic [6:0]  C_MIN_LINE   = 7'd5;
    localparam logic [6:0]  C_LINE_RST   = 7'd72;
    // ceil(2^38 / 85): exact quotient by 85 for any 32-bit value
    localparam logic [31:0] C_RECIP_85   = 32'hC0C0C0C1;
    localparam int unsigned C_RECIP_SHR  = 38;

endpackage

// ===== src/a85_front.sv =====
module a85_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  a85_pkg::t_in_item i_item,
    input  logic              i_fifo_full,
    output logic              o_full,
    output logic              o_job_push,
    output a85_pkg::t_job     o_job
);
    import a85_pkg::*;

    logic [23:0] r_bytes;
    logic [1:0]  r_fill;
    logic [23:0] n_bytes;
    logic        accept;
    logic        grp_full;

    assign o_full   = i_fifo_full;
    assign accept   = i_push && !i_fifo_full;
    assign grp_full = (r_fill == 2'd3);

    // place the byte at its slot in the pending group
    always_comb begin
        unique case (r_fill)
            2'd0:    n_bytes = r_bytes | {i_item.data_byte, 16'd0};
            2'd1:    n_bytes = r_bytes | {8'd0, i_item.data_byte, 8'd0};
            2'd2:    n_bytes = r_bytes | {16'd0, i_item.data_byte};
            default: n_bytes = r_bytes;
        endcase
    end

    // job for a completed group or a flushed partial group
    always_comb begin
        o_job.last = i_item.last_byte;
        if (grp_full) begin
            o_job.value    = {r_bytes, i_item.data_byte};
            o_job.n_dig    = 3'(C_DIGITS);
            o_job.zero_grp = ({r_bytes, i_item.data_byte} == 32'd0);
        end else begin
            o_job.value    = {n_bytes, 8'd0};
            o_job.n_dig    = {1'b0, r_fill} + 3'd2;
            o_job.zero_grp = 1'b0;
        end
    end

    assign o_job_push = accept && (grp_full || i_item.last_byte);

    // group collector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= '0;
            r_fill  <= '0;
        end else if (accept) begin
            if (grp_full || i_item.last_byte) begin
                r_bytes <= '0;
                r_fill  <= '0;
            end else begin
                r_bytes <= n_bytes;
                r_fill  <= r_fill + 2'd1;
            end
        end
    end

endmodule

// ===== src/a85_fifo.sv =====
module a85_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  a85_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output a85_pkg::t_job o_data,
    output logic          o_empty
);
    import a85_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/a85_conv.sv =====
module a85_conv (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  a85_pkg::t_job   i_job,
    output logic            o_job_pop,
    output logic            o_hold_valid,
    output a85_pkg::t_chars o_hold,
    input  logic            i_hold_take
);
    import a85_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'(C_DIGITS - 1);

    logic            r_busy;
    logic [63:0]     r_prod;
    logic [2:0]      r_step;
    logic [4:0][6:0] r_dig;
    logic [2:0]      r_n;
    logic            r_zero;
    logic            r_last;
    logic            r_hold_valid;
    t_chars          r_hold;

    logic [31:0]     quot;
    logic [44:0]     frac85;
    logic [6:0]      rem;
    logic [6:0]      dig_ch;
    logic [63:0]     load_prod;
    logic [63:0]     step_prod;
    logic [4:0][6:0] new_dig;
    logic            can_fin;
    logic            step_go;
    logic            hold_load;

    assign o_job_pop    = !r_busy && i_job_valid;
    assign o_hold_valid = r_hold_valid;
    assign o_hold       = r_hold;

    // one base-85 digit per cycle from the reciprocal product, the last once the hold is free:
    // quotient is the top part, remainder = (fraction * 85) >> 38
    assign quot      = {6'd0, r_prod[63:C_RECIP_SHR]};
    assign frac85    = {1'b0, r_prod[37:0], 6'd0} + {3'd0, r_prod[37:0], 4'd0}
                     + {5'd0, r_prod[37:0], 2'd0} + {7'd0, r_prod[37:0]};
    assign rem       = frac85[44:C_RECIP_SHR];
    assign dig_ch    = rem + C_CH_OFFSET;
    assign load_prod = 64'(i_job.value) * 64'(C_RECIP_85);
    assign step_prod = 64'(quot) * 64'(C_RECIP_85);
    assign new_dig   = {r_dig[3:0], dig_ch};

    assign can_fin   = !r_hold_valid || i_hold_take;
    assign step_go   = r_busy && ((r_step != LAST_STEP) || can_fin);
    assign hold_load = step_go && (r_step == LAST_STEP);

    // digit loop and hand-off register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_step       <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            r_hold_valid <= hold_load || (r_hold_valid && !i_hold_take);
            if (o_job_pop) begin
                r_busy <= 1'b1;
                r_prod <= load_prod;
                r_step <= '0;
                r_n    <= i_job.n_dig;
                r_zero <= i_job.zero_grp;
                r_last <= i_job.last;
            end else if (step_go) begin
                r_prod <= step_prod;
                r_dig  <= new_dig;
                r_step <= r_step + 3'd1;
                if (r_step == LAST_STEP) begin
                    r_busy       <= 1'b0;
                    r_hold.last  <= r_last;
                    if (r_zero) begin
                        r_hold.chars <= {28'd0, C_CH_Z};
                        r_hold.n_chr <= 3'd1;
                    end else begin
                        r_hold.chars <= new_dig;
                        r_hold.n_chr <= r_n;
                    end
                end
            end
        end
    end

endmodule

// ===== src/a85_emit.sv =====
module a85_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [6:0]       i_line_len,
    input  logic             i_hold_valid,
    input  a85_pkg::t_chars  i_hold,
    output logic             o_hold_take,
    output a85_pkg::t_result o_result,
    output logic             o_empty,
    input  logic             i_pop
);
    import a85_pkg::*;

    logic            r_busy;
    logic [4:0][6:0] r_chars;
    logic [2:0]      r_rem;
    logic            r_last;
    logic            r_nl;
    logic [6:0]      r_col;
    logic            r_out_valid;
    t_result         r_out;

    logic [6:0]      eff_len;
    logic [6:0]      col1;
    logic            nl_due;
    logic            adv;
    logic            emit;
    logic            fin;
    t_result         res;

    assign o_result    = r_out;
    assign o_empty     = !r_out_valid;
    assign o_hold_take = !r_busy && i_hold_valid;

    assign eff_len = (i_line_len < C_MIN_LINE) ? C_MIN_LINE : i_line_len;
    assign col1    = r_col + 7'd1;
    assign nl_due  = (col1 >= eff_len);
    assign adv     = !r_out_valid || i_pop;
    assign emit    = r_busy && adv;

    // next character: pending newline or next digit
    always_comb begin
        if (r_nl) begin
            fin           = (r_rem == 3'd0);
            res.char_code = C_CH_NL;
        end else begin
            fin           = (r_rem == 3'd1) && !nl_due;
            res.char_code = r_chars[0];
        end
        res.last_of_run = fin;
        res.stream_done = fin && r_last;
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_nl        <= 1'b0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= emit;
            end
            if (emit) begin
                r_out <= res;
                if (r_nl) begin
                    r_nl  <= 1'b0;
                    r_col <= '0;
                end else begin
                    r_chars <= {7'd0, r_chars[4:1]};
                    r_rem   <= r_rem - 3'd1;
                    r_nl    <= nl_due;
                    r_col   <= (nl_due || (fin && r_last)) ? 7'd0 : col1;
                end
                if (fin) begin
                    r_busy <= 1'b0;
                end
            end else if (o_hold_take) begin
                r_busy  <= 1'b1;
                r_chars <= i_hold.chars;
                r_rem   <= i_hold.n_chr;
                r_last  <= i_hold.last;
            end
        end
    end

endmodule

// ===== src/ascii85_stream_encoder.sv =====
// ASCII85 stream encoder, one character per result item.
// Path from the byte that completes or ends a group to its first character: the job
// queue, the divider's load and digit steps, then the hand-off register.
// Throughput: one character per cycle within a group while results are popped; the
// sequencer and the base-85 unit each take a new group only once done with the last.
// Reset: synchronous active-low; clears the group, queue, column and sets line length 72.
module ascii85_stream_encoder #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  a85_pkg::t_in_item i_item,
    output logic              empty,
    input  logic              pop,
    output a85_pkg::t_result  o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import a85_pkg::*;

    localparam logic REG_LINE_LEN = 1'b0;

    logic [6:0] r_line_len;
    logic       cfg_wr;

    logic       job_push;
    t_job       job_in;
    logic       fifo_full;
    logic       fifo_empty;
    t_job       job_out;
    logic       job_pop;
    logic       hold_valid;
    t_chars     hold;
    logic       hold_take;

    // config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_LINE_LEN) ? {25'd0, r_line_len} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len <= C_LINE_RST;
        end else if (cfg_wr && (paddr[2] == REG_LINE_LEN)) begin
            r_line_len <= pwdata[6:0];
        end
    end

    // group collector
    a85_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_fifo_full (fifo_full),
        .o_full      (full),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    // job queue between front and back
    a85_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (fifo_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (fifo_empty)
    );

    // base-85 digit unit
    a85_conv u_conv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (!fifo_empty),
        .i_job        (job_out),
        .o_job_pop    (job_pop),
        .o_hold_valid (hold_valid),
        .o_hold       (hold),
        .i_hold_take  (hold_take)
    );

    // character sequencer with line breaks
    a85_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_len   (r_line_len),
        .i_hold_valid (hold_valid),
        .i_hold       (hold),
        .o_hold_take  (hold_take),
        .o_result     (o_result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    // end of stream is always the end of an item's run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.stream_done) |-> o_result.last_of_run)
        else $error("stream_done without last_of_run");

    // only legal ASCII85 characters leave the block
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_result.char_code == C_CH_NL) || (o_result.char_code == C_CH_Z)
                    || ((o_result.char_code >= 7'd33) && (o_result.char_code <= 7'd117))))
        else $error("illegal character code");

    // front never pushes a job into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !fifo_full)
        else $error("job queue overflow");

endmodule

// ===== dv/ascii85_stream_encoder_tb.sv =====
`timescale 1ns / 1ps

module ascii85_stream_encoder_tb;
    import a85_pkg::*;

    localparam logic [2:0]  ADDR_LINE_LENGTH = 3'd0;
    localparam int unsigned BASE_85          = 85;
    localparam int          DIR_ROWS         = 24;
    localparam int          PHASES           = 8;
    localparam int          SETTLE_CYCLES    = 20;

    // Directed row: one byte, optionally with its characters written out
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        logic [2:0]  n_typed;
        logic [39:0] text;
    } t_vector;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    t_in_item    i_item  = '0;
    logic        empty;
    logic        pop     = 1'b0;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state
    logic [6:0]  line_len;
    logic [23:0] pend_group;
    logic [1:0]  pend_fill;
    logic [6:0]  line_col;

    t_result     step_out [$];
    t_result     pending_chars [$];
    int          mismatch_count = 0;
    bit          idling_on = 1'b1;
    int          stall_left = 0;
    int          stream_left = 0;
    bit          zero_heavy = 1'b0;

    logic [6:0]  line_settings [PHASES] = '{7'd127, 7'd5, 7'd0, 7'd1, 7'd31, 7'd3,
                                            7'd100, 7'd72};

    // Short opening streams; expected text given where it is obvious
    t_vector directed_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 3'd2, "!!"},
        '{8'h00, 1'b0, 1'b1, 3'd0, ""},
        '{8'h00, 1'b0, 1'b1, 3'd0, ""},
        '{8'h00, 1'b0, 1'b1, 3'd0, ""},
        '{8'h00, 1'b1, 1'b1, 3'd1, "z"},
        '{8'hFF, 1'b0, 1'b1, 3'd0, ""},
        '{8'hFF, 1'b0, 1'b1, 3'd0, ""},
        '{8'hFF, 1'b0, 1'b1, 3'd0, ""},
        '{8'hFF, 1'b1, 1'b1, 3'd5, "s8W-!"},
        '{8'h00, 1'b0, 1'b1, 3'd0, ""},
        '{8'h00, 1'b0, 1'b1, 3'd0, ""},
        '{8'h00, 1'b1, 1'b1, 3'd4, "!!!!"},
        '{8'hFF, 1'b1, 1'b0, 3'd0, ""},
        '{8'h12, 1'b0, 1'b0, 3'd0, ""},
        '{8'h34, 1'b1, 1'b0, 3'd0, ""},
        '{8'hA5, 1'b0, 1'b0, 3'd0, ""},
        '{8'h5A, 1'b0, 1'b0, 3'd0, ""},
        '{8'hC3, 1'b0, 1'b0, 3'd0, ""},
        '{8'h3C, 1'b0, 1'b0, 3'd0, ""},
        '{8'h00, 1'b0, 1'b0, 3'd0, ""},
        '{8'h00, 1'b0, 1'b0, 3'd0, ""},
        '{8'h00, 1'b0, 1'b0, 3'd0, ""},
        '{8'h00, 1'b0, 1'b0, 3'd0, ""},
        '{8'h01, 1'b1, 1'b0, 3'd0, ""}
    };

    ascii85_stream_encoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("ascii85_stream_encoder_tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d", what, got, want);
        mismatch_count++;
    endtask

    // One output character, then a newline once the line is full
    function automatic void emit_char(input logic [6:0] ch);
        t_result    r;
        logic [6:0] eff;
        eff           = (line_len < C_MIN_LINE) ? C_MIN_LINE : line_len;
        r.char_code   = ch;
        r.last_of_run = 1'b0;
        r.stream_done = 1'b0;
        step_out.push_back(r);
        line_col = line_col + 7'd1;
        if (line_col >= eff) begin
            r.char_code = C_CH_NL;
            step_out.push_back(r);
            line_col = '0;
        end
    endfunction

    // Base-85 digits, most significant first; only the first count are sent
    function automatic void emit_digits(input logic [31:0] value, input int count);
        logic [6:0]  dig [C_DIGITS];
        logic [31:0] v;
        v = value;
        for (int i = C_DIGITS - 1; i >= 0; i--) begin
            dig[i] = 7'(v % BASE_85) + C_CH_OFFSET;
            v      = v / BASE_85;
        end
        for (int i = 0; i < count; i++)
            emit_char(dig[i]);
    endfunction

    // Characters caused by one accepted byte, left in step_out
    function automatic void encode_byte(input t_in_item it);
        logic [31:0] value;
        t_result     tail;
        step_out.delete();
        if (pend_fill == 2'd3) begin
            value = {pend_group, it.data_byte};
            if (value == '0)
                emit_char(C_CH_Z);
            else
                emit_digits(value, C_DIGITS);
            pend_group = '0;
            pend_fill  = '0;
        end else begin
            pend_group = pend_group | (24'(it.data_byte) << (16 - 8 * int'(pend_fill)));
            pend_fill  = pend_fill + 2'd1;
            // partial group at end of stream: zero-padded, k+1 digits
            if (it.last_byte)
                emit_digits({pend_group, 8'h00}, int'(pend_fill) + 1);
        end
        if (it.last_byte) begin
            pend_group = '0;
            pend_fill  = '0;
            line_col   = '0;
        end
        if (step_out.size() > 0) begin
            tail             = step_out.pop_back();
            tail.last_of_run = 1'b1;
            tail.stream_done = it.last_byte;
            step_out.push_back(tail);
        end
    endfunction

    task automatic push_byte(input t_in_item it);
        i_item <= it;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
    endtask

    task automatic sender_gap();
        if (idling_on && $urandom_range(0, 2) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Block must be quiet before a register write
    task automatic settle_block();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_line_length(input logic [6:0] len);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LINE_LENGTH;
        pwdata  <= {25'd0, len};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        line_len  = len;
        // read back the register
        @(posedge i_clk);
        if (prdata !== {25'd0, len})
            report_mismatch("prdata", prdata, len);
    endtask

    // Random streams of 1..13 bytes; some streams are mostly zero bytes
    task automatic send_random_bytes(input int count);
        t_in_item it;
        for (int k = 0; k < count; k++) begin
            if (stream_left == 0) begin
                stream_left = $urandom_range(1, 13);
                zero_heavy  = ($urandom_range(0, 3) == 0);
            end
            stream_left--;
            it.data_byte = (zero_heavy && $urandom_range(0, 7) != 0) ? 8'h00
                                                                     : 8'($urandom_range(0, 255));
            it.last_byte = (stream_left == 0);
            push_byte(it);
            encode_byte(it);
            foreach (step_out[i]) pending_chars.push_back(step_out[i]);
            sender_gap();
        end
    endtask

    // Result side: check each accepted item, then pace pop
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("char with nothing expected", o_result.char_code, 0);
            end else begin
                want = pending_chars.pop_front();
                if (o_result.char_code !== want.char_code)
                    report_mismatch("char_code", o_result.char_code, want.char_code);
                if (o_result.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", o_result.last_of_run, want.last_of_run);
                if (o_result.stream_done !== want.stream_done)
                    report_mismatch("stream_done", o_result.stream_done, want.stream_done);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
        end else if (idling_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 11);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    initial begin
        t_in_item it;
        t_vector  row;
        t_result  r;

        line_len   = C_LINE_RST;
        pend_group = '0;
        pend_fill  = '0;
        line_col   = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset line length
        for (int idx = 0; idx < DIR_ROWS; idx++) begin
            row          = directed_rows[idx];
            it.data_byte = row.data;
            it.last_byte = row.last;
            push_byte(it);
            encode_byte(it);
            if (row.typed) begin
                step_out.delete();
                for (int i = 0; i < int'(row.n_typed); i++) begin
                    r.char_code   = row.text[8 * (int'(row.n_typed) - 1 - i) +: 7];
                    r.last_of_run = (i == int'(row.n_typed) - 1);
                    r.stream_done = r.last_of_run && row.last;
                    step_out.push_back(r);
                end
            end
            foreach (step_out[i]) pending_chars.push_back(step_out[i]);
            sender_gap();
        end

        // Random part, one line length per phase; phases may end mid-stream,
        // so a lowered length can land below the current column
        for (int p = 0; p < PHASES; p++) begin
            settle_block();
            write_line_length(line_settings[p]);
            if (p == PHASES - 1)
                idling_on = 1'b0;
            if (p == 2) begin
                send_random_bytes(6);
                hold_until_drained();
                send_random_bytes(6);
            end else begin
                send_random_bytes(12);
            end
        end

        push <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("ascii85_stream_encoder_tb: clean");
        else
            $display("ascii85_stream_encoder_tb: errors");
        $finish;
    end

endmodule
